// File: hdl/thsamp_pkg.sv
// shared constants, register codes and stage records for the terrain height sampler
// used by every module of the block except the generic ram
package thsamp_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_DEPTH   = 256;

  localparam int ADDR_W      = 16;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int SAMPLE_W    = 16;
  localparam int POS_W       = 24;
  localparam int LEVEL_W     = 32;
  localparam int GAIN_W      = 32;
  localparam int SIZE_W      = 9;

  localparam int CX_BITS     = $clog2(MAX_WIDTH);
  localparam int CZ_BITS     = $clog2(MAX_DEPTH);
  localparam int GW_BITS     = $clog2(MAX_WIDTH + 1);
  localparam int GD_BITS     = $clog2(MAX_DEPTH + 1);

  localparam int FRAC_W      = 16;
  localparam int ONE_Q16     = 1 << FRAC_W;
  localparam int M_W         = 42;
  localparam int M_SPLIT     = 21;
  localparam int R_W         = 60;

  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;

  typedef enum logic [2:0] {
    REG_ORIGIN_X,
    REG_ORIGIN_Z,
    REG_INV_CELL_X,
    REG_INV_CELL_Z,
    REG_HEIGHT_GAIN,
    REG_GRID_WIDTH,
    REG_GRID_DEPTH
  } reg_idx_t;

  typedef struct packed {
    logic signed [POS_W-1:0] origin_x;
    logic signed [POS_W-1:0] origin_z;
    logic [POS_W-1:0]        inv_cell_x;
    logic [POS_W-1:0]        inv_cell_z;
    logic [GAIN_W-1:0]       height_gain;
    logic [SIZE_W-1:0]       grid_width;
    logic [SIZE_W-1:0]       grid_depth;
  } cfg_t;

  typedef struct packed {
    logic                      valid;
    logic                      query;
    logic [ADDR_W-1:0]         waddr;
    logic [SAMPLE_W-1:0]       wdata;
    logic [ADDR_W-1:0]         a00;
    logic [ADDR_W-1:0]         a10;
    logic [ADDR_W-1:0]         a01;
    logic [ADDR_W-1:0]         a11;
    logic                      lower;
    logic signed [M_W-1:0]     ma;
    logic signed [M_W-1:0]     mb;
    logic signed [LEVEL_W-1:0] water;
  } grid_out_t;

  typedef struct packed {
    logic                      valid;
    logic signed [R_W-1:0]     r;
    logic signed [LEVEL_W-1:0] water;
  } interp_out_t;

endpackage

// File: hdl/thsamp_ram.sv
// generic ram, one write port and two registered read ports
// no dependencies
module thsamp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: hdl/thsamp_grid.sv
// front stages: origin offset, reciprocal multiply, cell clamp, corner addresses
// and triangle choice; uses thsamp_pkg
module thsamp_grid
  import thsamp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  cfg_t                      cfg,
  input  logic                      req_valid,
  input  logic                      mode,
  input  logic [ADDR_W-1:0]         cell_index,
  input  logic [SAMPLE_W-1:0]       sample,
  input  logic signed [POS_W-1:0]   pos_x,
  input  logic signed [POS_W-1:0]   pos_z,
  input  logic signed [LEVEL_W-1:0] water_level,
  input  logic                      load_next,
  output logic                      load_first,
  output grid_out_t                 g_out
);

  localparam int D_W     = POS_W + 1;
  localparam int P_W     = 2 * D_W;
  localparam int G_W     = P_W - 1;
  localparam int G_FRAC  = 24;
  localparam int G_SHIFT = 8;
  localparam int ROW_W   = CZ_BITS + GW_BITS;

  localparam logic signed [M_W-1:0] ONE_M = M_W'(ONE_Q16);

  logic ld1, ld2, ld3, ld4;
  logic v1, v2, v3, v4;

  // stage 1
  logic                      q1;
  logic [ADDR_W-1:0]         wa1;
  logic [SAMPLE_W-1:0]       wd1;
  logic signed [D_W-1:0]     dx1, dz1;
  logic signed [LEVEL_W-1:0] wl1;

  // stage 2
  logic                      q2;
  logic [ADDR_W-1:0]         wa2;
  logic [SAMPLE_W-1:0]       wd2;
  logic signed [G_W-1:0]     gx2, gz2;
  logic signed [LEVEL_W-1:0] wl2;

  // stage 3
  logic                      q3;
  logic [ADDR_W-1:0]         wa3;
  logic [SAMPLE_W-1:0]       wd3;
  logic [CX_BITS-1:0]        xi3;
  logic [CZ_BITS-1:0]        zi3;
  logic signed [M_W-1:0]     fx3, fz3;
  logic signed [LEVEL_W-1:0] wl3;

  // stage 4
  logic                      q4;
  logic [ADDR_W-1:0]         wa4;
  logic [SAMPLE_W-1:0]       wd4;
  logic [ADDR_W-1:0]         a00_4, a10_4, a01_4, a11_4;
  logic                      lower4;
  logic signed [M_W-1:0]     ma4, mb4;
  logic signed [LEVEL_W-1:0] wl4;

  logic signed [D_W-1:0]     dx_next, dz_next;
  logic signed [P_W-1:0]     prod_x, prod_z;
  logic [GW_BITS-1:0]        w;
  logic [GD_BITS-1:0]        d;
  logic [CX_BITS-1:0]        lim_x, xi_next;
  logic [CZ_BITS-1:0]        lim_z, zi_next;
  logic signed [M_W-1:0]     fx_next, fz_next;
  logic [ROW_W-1:0]          row_prod, lin;
  logic [ADDR_W-1:0]         a00_next;
  logic signed [M_W:0]       fsum;
  logic                      lower_next;

  assign ld4 = !v4 || load_next;
  assign ld3 = !v3 || ld4;
  assign ld2 = !v2 || ld3;
  assign ld1 = !v1 || ld2;
  assign load_first = ld1;

  // grid size limits
  always_comb begin
    if (cfg.grid_width < SIZE_W'(2)) begin
      w = GW_BITS'(2);
    end else if (32'(cfg.grid_width) > 32'(MAX_WIDTH)) begin
      w = GW_BITS'(MAX_WIDTH);
    end else begin
      w = GW_BITS'(cfg.grid_width);
    end
    if (cfg.grid_depth < SIZE_W'(2)) begin
      d = GD_BITS'(2);
    end else if (32'(cfg.grid_depth) > 32'(MAX_DEPTH)) begin
      d = GD_BITS'(MAX_DEPTH);
    end else begin
      d = GD_BITS'(cfg.grid_depth);
    end
    lim_x = CX_BITS'(w - GW_BITS'(2));
    lim_z = CZ_BITS'(d - GD_BITS'(2));
  end

  assign dx_next = $signed({pos_x[POS_W-1], pos_x}) - $signed({cfg.origin_x[POS_W-1], cfg.origin_x});
  assign dz_next = $signed({pos_z[POS_W-1], pos_z}) - $signed({cfg.origin_z[POS_W-1], cfg.origin_z});

  assign prod_x = dx1 * $signed({1'b0, cfg.inv_cell_x});
  assign prod_z = dz1 * $signed({1'b0, cfg.inv_cell_z});

  // cell index and fraction
  always_comb begin
    if (gx2[G_W-1]) begin
      xi_next = '0;
    end else if (gx2[G_W-2:G_FRAC] > 24'(lim_x)) begin
      xi_next = lim_x;
    end else begin
      xi_next = CX_BITS'(gx2[G_W-2:G_FRAC]);
    end
    if (gz2[G_W-1]) begin
      zi_next = '0;
    end else if (gz2[G_W-2:G_FRAC] > 24'(lim_z)) begin
      zi_next = lim_z;
    end else begin
      zi_next = CZ_BITS'(gz2[G_W-2:G_FRAC]);
    end
    fx_next = M_W'($signed(gx2[G_W-1:G_SHIFT])) - $signed(M_W'({xi_next, FRAC_W'(0)}));
    fz_next = M_W'($signed(gz2[G_W-1:G_SHIFT])) - $signed(M_W'({zi_next, FRAC_W'(0)}));
  end

  // corner address and triangle
  always_comb begin
    row_prod   = zi3 * w;
    lin        = row_prod + ROW_W'(xi3);
    a00_next   = ADDR_W'(lin);
    fsum       = (M_W+1)'(fx3) + (M_W+1)'(fz3);
    lower_next = fsum < (M_W+1)'(ONE_M);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (ld1) v1 <= req_valid;
      if (ld2) v2 <= v1;
      if (ld3) v3 <= v2;
      if (ld4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      q1  <= mode;
      wa1 <= cell_index;
      wd1 <= sample;
      dx1 <= dx_next;
      dz1 <= dz_next;
      wl1 <= water_level;
    end
    if (ld2) begin
      q2  <= q1;
      wa2 <= wa1;
      wd2 <= wd1;
      gx2 <= prod_x[G_W-1:0];
      gz2 <= prod_z[G_W-1:0];
      wl2 <= wl1;
    end
    if (ld3) begin
      q3  <= q2;
      wa3 <= wa2;
      wd3 <= wd2;
      xi3 <= xi_next;
      zi3 <= zi_next;
      fx3 <= fx_next;
      fz3 <= fz_next;
      wl3 <= wl2;
    end
    if (ld4) begin
      q4     <= q3;
      wa4    <= wa3;
      wd4    <= wd3;
      a00_4  <= a00_next;
      a10_4  <= a00_next + ADDR_W'(1);
      a01_4  <= a00_next + ADDR_W'(w);
      a11_4  <= a00_next + ADDR_W'(w) + ADDR_W'(1);
      lower4 <= lower_next;
      ma4    <= lower_next ? fx3 : ONE_M - fz3;
      mb4    <= lower_next ? fz3 : ONE_M - fx3;
      wl4    <= wl3;
    end
  end

  always_comb begin
    g_out.valid = v4;
    g_out.query = q4;
    g_out.waddr = wa4;
    g_out.wdata = wd4;
    g_out.a00   = a00_4;
    g_out.a10   = a10_4;
    g_out.a01   = a01_4;
    g_out.a11   = a11_4;
    g_out.lower = lower4;
    g_out.ma    = ma4;
    g_out.mb    = mb4;
    g_out.water = wl4;
  end

endmodule

// File: hdl/thsamp_interp.sv
// middle stages: corner differences, split slope products and the raw triangle sum
// uses thsamp_pkg; corner samples arrive from the ram read registers
module thsamp_interp
  import thsamp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  grid_out_t           g_in,
  input  logic [SAMPLE_W-1:0] s00,
  input  logic [SAMPLE_W-1:0] s10,
  input  logic [SAMPLE_W-1:0] s01,
  input  logic [SAMPLE_W-1:0] s11,
  input  logic                load_next,
  output logic                load_first,
  output interp_out_t         i_out
);

  localparam int D_W  = SAMPLE_W + 1;
  localparam int PL_W = D_W + M_SPLIT + 1;
  localparam int PH_W = D_W + M_W - M_SPLIT;

  logic ld5, ld6, ld7, ld8;
  logic v5, v6, v7, v8;

  logic                      lower5;
  logic signed [M_W-1:0]     ma5, mb5;
  logic signed [LEVEL_W-1:0] wl5;

  logic [SAMPLE_W-1:0]       base6;
  logic signed [PL_W-1:0]    pa_lo6, pb_lo6;
  logic signed [PH_W-1:0]    pa_hi6, pb_hi6;
  logic signed [LEVEL_W-1:0] wl6;

  logic [SAMPLE_W-1:0]       base7;
  logic signed [R_W-1:0]     sa7, sb7;
  logic signed [LEVEL_W-1:0] wl7;

  logic signed [R_W-1:0]     r8;
  logic signed [LEVEL_W-1:0] wl8;

  logic [SAMPLE_W-1:0]       pivot;
  logic signed [D_W-1:0]     da, db;
  logic signed [PL_W-1:0]    pa_lo_next, pb_lo_next;
  logic signed [PH_W-1:0]    pa_hi_next, pb_hi_next;

  assign ld8 = !v8 || load_next;
  assign ld7 = !v7 || ld8;
  assign ld6 = !v6 || ld7;
  assign ld5 = !v5 || ld6;
  assign load_first = ld5;

  // lower triangle pivots on s00, upper on s11
  always_comb begin
    pivot      = lower5 ? s00 : s11;
    da         = $signed({1'b0, s10}) - $signed({1'b0, pivot});
    db         = $signed({1'b0, s01}) - $signed({1'b0, pivot});
    pa_lo_next = PL_W'(da) * PL_W'($signed({1'b0, ma5[M_SPLIT-1:0]}));
    pb_lo_next = PL_W'(db) * PL_W'($signed({1'b0, mb5[M_SPLIT-1:0]}));
    pa_hi_next = PH_W'(da) * PH_W'($signed(ma5[M_W-1:M_SPLIT]));
    pb_hi_next = PH_W'(db) * PH_W'($signed(mb5[M_W-1:M_SPLIT]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else begin
      if (ld5) v5 <= g_in.valid && g_in.query;
      if (ld6) v6 <= v5;
      if (ld7) v7 <= v6;
      if (ld8) v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (ld5) begin
      lower5 <= g_in.lower;
      ma5    <= g_in.ma;
      mb5    <= g_in.mb;
      wl5    <= g_in.water;
    end
    if (ld6) begin
      base6  <= pivot;
      pa_lo6 <= pa_lo_next;
      pa_hi6 <= pa_hi_next;
      pb_lo6 <= pb_lo_next;
      pb_hi6 <= pb_hi_next;
      wl6    <= wl5;
    end
    if (ld7) begin
      base7 <= base6;
      sa7   <= R_W'(pa_lo6) + (R_W'(pa_hi6) <<< M_SPLIT);
      sb7   <= R_W'(pb_lo6) + (R_W'(pb_hi6) <<< M_SPLIT);
      wl7   <= wl6;
    end
    if (ld8) begin
      r8  <= sa7 + sb7 + $signed(R_W'({base7, FRAC_W'(0)}));
      wl8 <= wl7;
    end
  end

  always_comb begin
    i_out.valid = v8;
    i_out.r     = r8;
    i_out.water = wl8;
  end

endmodule

// File: hdl/thsamp_scale.sv
// back stages: height gain, saturation and the water floor, ending in the result register
// uses thsamp_pkg
module thsamp_scale
  import thsamp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  interp_out_t               i_in,
  input  logic [GAIN_W-1:0]         gain,
  input  logic                      res_stall,
  output logic                      load_first,
  output logic                      res_valid,
  output logic signed [LEVEL_W-1:0] ground_height,
  output logic                      water_clamped
);

  localparam int R_FRAC = 24;
  localparam int RH_W   = R_W - R_FRAC;
  localparam int HP_W   = 64;
  localparam int LP_W   = R_FRAC + GAIN_W;
  localparam int HS_W   = HP_W + 1;

  localparam logic signed [RH_W-1:0]    RH_TOP = {{(RH_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [RH_W-1:0]    RH_BOT = -RH_TOP;
  localparam logic signed [HS_W-1:0]    HS_TOP = {{(HS_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [HS_W-1:0]    HS_BOT = -HS_TOP - HS_W'(1);
  localparam logic signed [LEVEL_W-1:0] H_MAX  = {1'b0, {(LEVEL_W-1){1'b1}}};
  localparam logic signed [LEVEL_W-1:0] H_MIN  = {1'b1, {(LEVEL_W-1){1'b0}}};

  logic ld9, ld10, ld11;
  logic v9, v10;

  logic                      sat_hi9, sat_lo9, gz9;
  logic signed [HP_W-1:0]    phi9;
  logic [LP_W-1:0]           plo9;
  logic signed [LEVEL_W-1:0] wl9;

  logic signed [LEVEL_W-1:0] h10;
  logic signed [LEVEL_W-1:0] wl10;

  logic signed [RH_W-1:0]    rh;
  logic [R_FRAC-1:0]         rl;
  logic signed [HP_W-1:0]    phi_next;
  logic [LP_W-1:0]           plo_next;
  logic signed [HS_W-1:0]    hs;
  logic signed [LEVEL_W-1:0] h_next;

  assign ld11 = !res_valid || !res_stall;
  assign ld10 = !v10 || ld11;
  assign ld9  = !v9 || ld10;
  assign load_first = ld9;

  always_comb begin
    rh       = $signed(i_in.r[R_W-1:R_FRAC]);
    rl       = i_in.r[R_FRAC-1:0];
    phi_next = HP_W'($signed(rh[LEVEL_W-1:0])) * HP_W'($signed({1'b0, gain}));
    plo_next = LP_W'(rl) * LP_W'(gain);
  end

  always_comb begin
    hs = HS_W'(phi9) + $signed(HS_W'(plo9[LP_W-1:R_FRAC]));
    if (gz9) begin
      h_next = '0;
    end else if (sat_hi9) begin
      h_next = H_MAX;
    end else if (sat_lo9) begin
      h_next = H_MIN;
    end else if (hs > HS_TOP) begin
      h_next = H_MAX;
    end else if (hs < HS_BOT) begin
      h_next = H_MIN;
    end else begin
      h_next = hs[LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v9        <= 1'b0;
      v10       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (ld9)  v9        <= i_in.valid;
      if (ld10) v10       <= v9;
      if (ld11) res_valid <= v10;
    end
  end

  always_ff @(posedge clk) begin
    if (ld9) begin
      sat_hi9 <= rh > RH_TOP;
      sat_lo9 <= rh < RH_BOT;
      gz9     <= gain == '0;
      phi9    <= phi_next;
      plo9    <= plo_next;
      wl9     <= i_in.water;
    end
    if (ld10) begin
      h10  <= h_next;
      wl10 <= wl9;
    end
    if (ld11) begin
      water_clamped <= h10 <= wl10;
      ground_height <= (h10 <= wl10) ? wl10 : h10;
    end
  end

endmodule

// File: hdl/terrain_height_sampler_core.sv
// top level of the terrain height sampler: config registers, height store, pipeline
// uses thsamp_pkg, thsamp_ram, thsamp_grid, thsamp_interp, thsamp_scale
//
// usage
//   config port: apb-style, registers at byte address 4*index, always ready; the user
//   must write them only while no request is in flight, the block does not enforce it.
//   request channel (req_valid / req_stall): mode 0 stores sample at
//   cell_index and gives no result; mode 1 asks for the ground height at
//   pos_x / pos_z, floored at water_level.
//   result channel (res_valid / res_stall): ground_height and water_clamped,
//   one per query, in request order.
//   throughput: one request per cycle while req_stall is low, any mix of writes and queries.
//   pipeline: eleven register stages, the ram read sits between stages four and five.
//   the height store is two copies of 64k x 16 ram, each with two read ports,
//   so the four corners are read in the same cycle.
//   reset clears the stage valid bits and the config registers to their
//   defaults; store contents are undefined until written.
//   res_stall holds the result register; earlier stages keep moving into
//   empty slots, and req_stall rises only once all eleven stages are full.
module terrain_height_sampler_core
  import thsamp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PADDR_W-1:0]        paddr,
  input  logic [PDATA_W-1:0]        pwdata,
  output logic [PDATA_W-1:0]        prdata,
  output logic                      pready,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  logic                      mode,
  input  logic [ADDR_W-1:0]         cell_index,
  input  logic [SAMPLE_W-1:0]       sample,
  input  logic signed [POS_W-1:0]   pos_x,
  input  logic signed [POS_W-1:0]   pos_z,
  input  logic signed [LEVEL_W-1:0] water_level,
  output logic                      res_valid,
  input  logic                      res_stall,
  output logic signed [LEVEL_W-1:0] ground_height,
  output logic                      water_clamped
);

  cfg_t        cfg;
  reg_idx_t    idx;
  logic        cfg_we;
  grid_out_t   g2i;
  interp_out_t i2s;
  logic        grid_load, interp_load, scale_load;
  logic        ram_we;
  logic [SAMPLE_W-1:0] s00, s10, s01, s11;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x    <= '0;
      cfg.origin_z    <= '0;
      cfg.inv_cell_x  <= POS_W'(ONE_Q16);
      cfg.inv_cell_z  <= POS_W'(ONE_Q16);
      cfg.height_gain <= GAIN_W'(ONE_Q16);
      cfg.grid_width  <= SIZE_W'(256);
      cfg.grid_depth  <= SIZE_W'(256);
    end else if (cfg_we) begin
      case (idx)
        REG_ORIGIN_X:    cfg.origin_x    <= pwdata[POS_W-1:0];
        REG_ORIGIN_Z:    cfg.origin_z    <= pwdata[POS_W-1:0];
        REG_INV_CELL_X:  cfg.inv_cell_x  <= pwdata[POS_W-1:0];
        REG_INV_CELL_Z:  cfg.inv_cell_z  <= pwdata[POS_W-1:0];
        REG_HEIGHT_GAIN: cfg.height_gain <= pwdata[GAIN_W-1:0];
        REG_GRID_WIDTH:  cfg.grid_width  <= pwdata[SIZE_W-1:0];
        REG_GRID_DEPTH:  cfg.grid_depth  <= pwdata[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ORIGIN_X:    prdata = PDATA_W'(cfg.origin_x[POS_W-1:0]);
      REG_ORIGIN_Z:    prdata = PDATA_W'(cfg.origin_z[POS_W-1:0]);
      REG_INV_CELL_X:  prdata = PDATA_W'(cfg.inv_cell_x);
      REG_INV_CELL_Z:  prdata = PDATA_W'(cfg.inv_cell_z);
      REG_HEIGHT_GAIN: prdata = PDATA_W'(cfg.height_gain);
      REG_GRID_WIDTH:  prdata = PDATA_W'(cfg.grid_width);
      REG_GRID_DEPTH:  prdata = PDATA_W'(cfg.grid_depth);
      default:         prdata = '0;
    endcase
  end

  assign req_stall = !grid_load;

  thsamp_grid u_grid (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .req_valid   (req_valid),
    .mode        (mode),
    .cell_index  (cell_index),
    .sample      (sample),
    .pos_x       (pos_x),
    .pos_z       (pos_z),
    .water_level (water_level),
    .load_next   (interp_load),
    .load_first  (grid_load),
    .g_out       (g2i)
  );

  // writes land at the same edge the corner reads happen, keeping request order
  assign ram_we = g2i.valid && !g2i.query && interp_load;

  thsamp_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (STORE_DEPTH)
  ) u_ram_row0 (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (g2i.waddr),
    .wdata   (g2i.wdata),
    .re      (interp_load),
    .raddr_a (g2i.a00),
    .raddr_b (g2i.a10),
    .rdata_a (s00),
    .rdata_b (s10)
  );

  thsamp_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (STORE_DEPTH)
  ) u_ram_row1 (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (g2i.waddr),
    .wdata   (g2i.wdata),
    .re      (interp_load),
    .raddr_a (g2i.a01),
    .raddr_b (g2i.a11),
    .rdata_a (s01),
    .rdata_b (s11)
  );

  thsamp_interp u_interp (
    .clk        (clk),
    .rst        (rst),
    .g_in       (g2i),
    .s00        (s00),
    .s10        (s10),
    .s01        (s01),
    .s11        (s11),
    .load_next  (scale_load),
    .load_first (interp_load),
    .i_out      (i2s)
  );

  thsamp_scale u_scale (
    .clk           (clk),
    .rst           (rst),
    .i_in          (i2s),
    .gain          (cfg.height_gain),
    .res_stall     (res_stall),
    .load_first    (scale_load),
    .res_valid     (res_valid),
    .ground_height (ground_height),
    .water_clamped (water_clamped)
  );

`ifndef ASSERT_OFF
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> res_valid && res_stall)
    else $error("request stalled while the result side is free");

  a_reset_clears_result: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  a_write_reaches_store: assert property (@(posedge clk) disable iff (rst)
    g2i.valid && !g2i.query && req_stall |-> !ram_we)
    else $error("store written while the whole pipeline is held");
`endif

endmodule
